>>> sv/blm_pkg.sv
`timescale 1ns / 1ps
// shared constants for the battery level monitor
package blm_pkg;

    typedef logic [1:0] level_t;

    localparam level_t LEVEL_LOW  = 2'd0;
    localparam level_t LEVEL_MED  = 2'd1;
    localparam level_t LEVEL_HIGH = 2'd2;

    localparam int CFG_IDX_W = 3;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_FULL_SCALE = 3'd0;
    localparam cfg_idx_t CFG_ADC_BITS   = 3'd1;
    localparam cfg_idx_t CFG_LOW_TH     = 3'd2;
    localparam cfg_idx_t CFG_HIGH_TH    = 3'd3;
    localparam cfg_idx_t CFG_HYST       = 3'd4;
    localparam cfg_idx_t CFG_WINDOW     = 3'd5;

    localparam int MV_W      = 16;
    localparam int RAW_W     = 16;
    localparam int BITS_W    = 5;
    localparam int WIN_CFG_W = 6;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 40;

    localparam logic [BITS_W-1:0] ADC_BITS_MIN = 5'd8;
    localparam logic [BITS_W-1:0] ADC_BITS_MAX = 5'd16;

    localparam logic [MV_W-1:0]      RST_FULL_SCALE = 16'd3300;
    localparam logic [BITS_W-1:0]    RST_ADC_BITS   = 5'd12;
    localparam logic [MV_W-1:0]      RST_LOW_TH     = 16'd3300;
    localparam logic [MV_W-1:0]      RST_HIGH_TH    = 16'd4000;
    localparam logic [MV_W-1:0]      RST_HYST       = 16'd100;
    localparam logic [WIN_CFG_W-1:0] RST_WINDOW     = 6'd8;

endpackage

>>> sv/battery_level_monitor.sv
`timescale 1ns / 1ps
// battery level monitor: serial scaling, moving average and hysteresis level
//
// One ADC code per transaction is scaled to millivolts, averaged over a ring of
// window_length samples and classified low, medium or high with hysteresis once
// the ring is full. One item is worked at a time: from acceptance to the next
// acceptance it passes a 2-bit-per-cycle multiplier, 16 steps of the
// bit-serial divider for the scaling, a ring and sum update, Q divider steps
// for the average, where Q = 16 + max(1, clog2(MAX_WINDOW)), an output state
// that waits for the master side and an idle state in which the next
// transaction is taken. A new item is taken while a finished
// result still waits on the master side. Writing window_length clears the
// averaging state and keeps the level; no clearing pass is needed after reset.
module battery_level_monitor
    import blm_pkg::*;
#(
    parameter int MAX_WINDOW = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // raw_sample
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // sample_mv, average_mv, battery_level, level_changed, averaging_ready, zero pad
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [MV_W-1:0]       cfg_wdata
);

    localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = MV_W + PTR_W;
    localparam int QW    = (SUM_W > MV_W) ? SUM_W : MV_W;
    localparam int STEP_W = $clog2(QW + 1);
    localparam int PROD_W = 2 * MV_W;
    localparam int MUL_STEPS = RAW_W / 2;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_DIV1 = 3'd2;
    localparam logic [2:0] ST_SUM  = 3'd3;
    localparam logic [2:0] ST_DIV2 = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [MV_W-1:0]      fs_reg, low_reg, high_reg, hyst_reg;
    logic [BITS_W-1:0]    bits_reg;
    logic [WIN_CFG_W-1:0] win_cfg_reg;

    logic [2:0]           state_reg, state_next;
    logic [STEP_W-1:0]    step_reg;
    logic [RAW_W-1:0]     raw_sh_reg;
    logic [PROD_W-1:0]    acc_reg;
    logic [MV_W-1:0]      rem_reg;
    logic [QW-1:0]        quo_reg;
    logic [MV_W-1:0]      divisor_reg;
    logic [MV_W-1:0]      sample_reg;
    logic [MV_W-1:0]      rd_reg;

    logic [PTR_W-1:0]     wp_reg;
    logic [CNT_W-1:0]     fill_reg;
    logic [SUM_W-1:0]     sum_reg;
    level_t               level_reg;

    logic                 m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    logic [MV_W-1:0]      ring [MAX_WINDOW];

    // effective settings
    logic [BITS_W-1:0]    bits_eff;
    logic [MV_W-1:0]      maxcode;
    logic [RAW_W-1:0]     raw_clamped;
    logic [CNT_W-1:0]     win_eff;
    logic                 ring_full;
    logic [CNT_W:0]       wp_inc;

    always_comb begin
        if (bits_reg < ADC_BITS_MIN) begin
            bits_eff = ADC_BITS_MIN;
        end else if (bits_reg > ADC_BITS_MAX) begin
            bits_eff = ADC_BITS_MAX;
        end else begin
            bits_eff = bits_reg;
        end
        maxcode = {MV_W{1'b1}} >> (ADC_BITS_MAX - bits_eff);
        raw_clamped = (s_tdata > maxcode) ? maxcode : s_tdata;
        if (win_cfg_reg == '0) begin
            win_eff = CNT_W'(1);
        end else if (32'(win_cfg_reg) > MAX_WINDOW) begin
            win_eff = CNT_W'(MAX_WINDOW);
        end else begin
            win_eff = CNT_W'(win_cfg_reg);
        end
        ring_full = (fill_reg >= win_eff);
        wp_inc = (CNT_W+1)'(wp_reg) + (CNT_W+1)'(1);
    end

    // radix-4 multiply step
    logic [1:0]        mul_digit;
    logic [MV_W+1:0]   mul_part;
    logic [PROD_W-1:0] acc_next;

    always_comb begin
        mul_digit = raw_sh_reg[RAW_W-1 -: 2];
        mul_part = (mul_digit[0] ? (MV_W+2)'(fs_reg) : '0)
                 + (mul_digit[1] ? {1'b0, fs_reg, 1'b0} : '0);
        acc_next = {acc_reg[PROD_W-3:0], 2'b00} + PROD_W'(mul_part);
    end

    // restoring divider step, one quotient bit per cycle
    logic [MV_W:0]   div_trial;
    logic            div_ge;
    logic [MV_W-1:0] rem_next;
    logic [QW-1:0]   quo_next;

    always_comb begin
        div_trial = {rem_reg, quo_reg[QW-1]};
        div_ge = (div_trial >= {1'b0, divisor_reg});
        rem_next = div_ge ? MV_W'(div_trial - {1'b0, divisor_reg}) : div_trial[MV_W-1:0];
        quo_next = {quo_reg[QW-2:0], div_ge};
    end

    // level decision on the finished average
    logic [MV_W-1:0] avg;
    logic            ready;
    logic [MV_W:0]   low_plus_hyst, avg_plus_hyst;
    level_t          level_cur, level_new;

    always_comb begin
        avg = quo_reg[MV_W-1:0];
        ready = (fill_reg >= win_eff);
        low_plus_hyst = {1'b0, low_reg} + {1'b0, hyst_reg};
        avg_plus_hyst = {1'b0, avg} + {1'b0, hyst_reg};
        level_cur = (level_reg == LEVEL_LOW || level_reg == LEVEL_HIGH) ? level_reg : LEVEL_MED;
        level_new = level_cur;
        if (ready) begin
            unique case (level_cur)
                LEVEL_LOW: begin
                    if ({1'b0, avg} >= low_plus_hyst) level_new = LEVEL_MED;
                end
                LEVEL_HIGH: begin
                    if (avg_plus_hyst <= {1'b0, high_reg}) level_new = LEVEL_MED;
                end
                default: begin
                    if (avg <= low_reg) begin
                        level_new = LEVEL_LOW;
                    end else if (avg >= high_reg) begin
                        level_new = LEVEL_HIGH;
                    end
                end
            endcase
        end
    end

    logic out_free;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = ST_MUL;
            ST_MUL:  if (step_reg == '0) state_next = ST_DIV1;
            ST_DIV1: if (step_reg == '0) state_next = ST_SUM;
            ST_SUM:  state_next = ST_DIV2;
            ST_DIV2: if (step_reg == '0) state_next = ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // sample ring
    always_ff @(posedge aclk) begin
        if (state_reg == ST_SUM) begin
            ring[wp_reg] <= sample_reg;
        end
        rd_reg <= ring[wp_reg];
    end

    // datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                raw_sh_reg <= raw_clamped;
                acc_reg <= '0;
                divisor_reg <= maxcode;
                step_reg <= STEP_W'(MUL_STEPS - 1);
            end
            ST_MUL: begin
                acc_reg <= acc_next;
                raw_sh_reg <= {raw_sh_reg[RAW_W-3:0], 2'b00};
                if (step_reg == '0) begin
                    rem_reg <= acc_next[PROD_W-1:MV_W];
                    quo_reg <= {acc_next[MV_W-1:0], {(QW-MV_W){1'b0}}};
                    step_reg <= STEP_W'(MV_W - 1);
                end else begin
                    step_reg <= step_reg - 1'b1;
                end
            end
            ST_DIV1: begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                if (step_reg == '0) begin
                    sample_reg <= quo_next[MV_W-1:0];
                end else begin
                    step_reg <= step_reg - 1'b1;
                end
            end
            ST_SUM: begin
                rem_reg <= '0;
                quo_reg <= QW'(sum_reg - (ring_full ? SUM_W'(rd_reg) : '0)
                               + SUM_W'(sample_reg));
                divisor_reg <= MV_W'(ring_full ? fill_reg : fill_reg + 1'b1);
                step_reg <= STEP_W'(QW - 1);
            end
            ST_DIV2: begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                if (step_reg != '0) step_reg <= step_reg - 1'b1;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tdata_reg <= {4'b0000, ready, (level_new != level_cur), level_new,
                                    avg, sample_reg};
                end
            end
            default: begin
                step_reg <= '0;
            end
        endcase
    end

    // control and averaging state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            fs_reg       <= RST_FULL_SCALE;
            bits_reg     <= RST_ADC_BITS;
            low_reg      <= RST_LOW_TH;
            high_reg     <= RST_HIGH_TH;
            hyst_reg     <= RST_HYST;
            win_cfg_reg  <= RST_WINDOW;
            wp_reg       <= '0;
            fill_reg     <= '0;
            sum_reg      <= '0;
            level_reg    <= LEVEL_MED;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_FULL_SCALE: fs_reg <= cfg_wdata;
                    CFG_ADC_BITS:   bits_reg <= cfg_wdata[BITS_W-1:0];
                    CFG_LOW_TH:     low_reg <= cfg_wdata;
                    CFG_HIGH_TH:    high_reg <= cfg_wdata;
                    CFG_HYST:       hyst_reg <= cfg_wdata;
                    CFG_WINDOW: begin
                        win_cfg_reg <= cfg_wdata[WIN_CFG_W-1:0];
                        wp_reg <= '0;
                        fill_reg <= '0;
                        sum_reg <= '0;
                    end
                    default: ;
                endcase
            end
            if (state_reg == ST_SUM) begin
                sum_reg <= sum_reg - (ring_full ? SUM_W'(rd_reg) : '0) + SUM_W'(sample_reg);
                wp_reg <= (wp_inc >= (CNT_W+1)'(win_eff)) ? '0 : PTR_W'(wp_inc);
                if (!ring_full) fill_reg <= fill_reg + 1'b1;
            end
            if (state_reg == ST_DONE && out_free) begin
                level_reg <= level_new;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> sim/tb_battery_level_monitor.sv
`timescale 1ns / 1ps
// testbench for battery_level_monitor: scaling, moving average and level hysteresis checks
module tb_battery_level_monitor;
    import blm_pkg::*;

    localparam int RING_DEPTH   = 32;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 100;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 152;

    localparam logic [RAW_W-1:0] WARMUP_CODES [8] = '{
        16'd0, 16'd4095, 16'hFFFF, 16'd1, 16'd2048, 16'd4096, 16'd4094, 16'd3000
    };
    localparam logic [RAW_W-1:0] LEVEL_WALK_CODES [12] = '{
        16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd3399, 16'd3400,
        16'd3999, 16'd4000, 16'd3901, 16'd3900, 16'd3301, 16'd3300
    };

    typedef struct packed {
        logic            averaging_ready;
        logic            level_changed;
        level_t          battery_level;
        logic [MV_W-1:0] average_mv;
        logic [MV_W-1:0] sample_mv;
    } reading_t;

    class level_tracker;
        logic [MV_W-1:0]      full_scale, low_th, high_th, hyst;
        logic [BITS_W-1:0]    adc_bits;
        logic [WIN_CFG_W-1:0] window;
        int unsigned          ring [RING_DEPTH];
        int unsigned          wr_ptr, fill, sum;
        level_t               level;
        reading_t             readings_due [$];
        int                   errors;

        function new();
            full_scale = RST_FULL_SCALE;
            adc_bits   = RST_ADC_BITS;
            low_th     = RST_LOW_TH;
            high_th    = RST_HIGH_TH;
            hyst       = RST_HYST;
            window     = RST_WINDOW;
            level      = LEVEL_MED;
            errors     = 0;
            clear_window();
        endfunction

        function void clear_window();
            foreach (ring[i]) ring[i] = 0;
            wr_ptr = 0;
            fill   = 0;
            sum    = 0;
        endfunction

        function int unsigned max_code();
            int unsigned bits;
            bits = adc_bits;
            if (bits < ADC_BITS_MIN) bits = ADC_BITS_MIN;
            if (bits > ADC_BITS_MAX) bits = ADC_BITS_MAX;
            return (32'd1 << bits) - 1;
        endfunction

        function int pending();
            return readings_due.size();
        endfunction

        function void configure(cfg_idx_t idx, logic [MV_W-1:0] value);
            case (idx)
                CFG_FULL_SCALE: full_scale = value;
                CFG_ADC_BITS:   adc_bits = value[BITS_W-1:0];
                CFG_LOW_TH:     low_th = value;
                CFG_HIGH_TH:    high_th = value;
                CFG_HYST:       hyst = value;
                CFG_WINDOW: begin
                    window = value[WIN_CFG_W-1:0];
                    clear_window();
                end
                default: ;
            endcase
        endfunction

        function void note_sample(logic [RAW_W-1:0] raw_code);
            int unsigned top, code, mv, win, avg, lo, hi, hy;
            reading_t    r;
            level_t      prev;
            top  = max_code();
            code = (raw_code > top) ? top : raw_code;
            mv   = (code * full_scale) / top;
            win  = (window == 0) ? 1 : (window > RING_DEPTH) ? RING_DEPTH : window;
            if (wr_ptr >= win) wr_ptr = 0;
            if (fill > win) fill = win;
            if (fill >= win) sum -= ring[wr_ptr];
            ring[wr_ptr] = mv;
            sum += mv;
            wr_ptr = (wr_ptr + 1 >= win) ? 0 : wr_ptr + 1;
            if (fill < win) fill++;
            avg = sum / fill;
            lo  = low_th;
            hi  = high_th;
            hy  = hyst;
            prev = level;
            r.averaging_ready = (fill >= win);
            if (r.averaging_ready) begin
                case (level)
                    LEVEL_LOW:  if (avg >= lo + hy) level = LEVEL_MED;
                    LEVEL_HIGH: if (hy <= hi && avg <= hi - hy) level = LEVEL_MED;
                    default: begin
                        if (avg <= lo) level = LEVEL_LOW;
                        else if (avg >= hi) level = LEVEL_HIGH;
                        else level = LEVEL_MED;
                    end
                endcase
            end
            r.sample_mv     = mv[MV_W-1:0];
            r.average_mv    = avg[MV_W-1:0];
            r.battery_level = level;
            r.level_changed = (level != prev);
            readings_due.push_back(r);
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 10) $display("mismatch at %0t: %s", $time, msg);
        endfunction

        function void compare(string name, int unsigned want, int unsigned got);
            if (want != got) report($sformatf("%s expected %0d, got %0d", name, want, got));
        endfunction

        function void check_reading(logic [OUT_DATA_W-1:0] data);
            reading_t got, want;
            got = data[$bits(reading_t)-1:0];
            if (readings_due.size() == 0) begin
                report($sformatf("transaction with nothing expected, tdata %h", data));
                return;
            end
            want = readings_due.pop_front();
            compare("sample_mv", want.sample_mv, got.sample_mv);
            compare("average_mv", want.average_mv, got.average_mv);
            compare("battery_level", want.battery_level, got.battery_level);
            compare("level_changed", want.level_changed, got.level_changed);
            compare("averaging_ready", want.averaging_ready, got.averaging_ready);
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_FULL_SCALE;
    logic [MV_W-1:0]       cfg_wdata = '0;

    logic idle_on   = 1'b1;
    int   hold_reqs = 0;
    int   hold_seen = 0;
    int   hold_left = 0;
    int   rx_gap    = 0;

    level_tracker sb = new();

    battery_level_monitor #(
        .MAX_WINDOW(RING_DEPTH)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #4 aclk = ~aclk;

    // result side back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            rx_gap    <= 0;
            hold_left <= 0;
            hold_seen <= 0;
        end else if (hold_reqs != hold_seen) begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (rx_gap != 0) begin
            rx_gap   <= rx_gap - 1;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            rx_gap   <= $urandom_range(0, 11);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) sb.check_reading(m_tdata);
            if (s_tvalid && s_tready) sb.note_sample(s_tdata);
        end
    end

    task automatic send_sample(input logic [RAW_W-1:0] raw_code);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= raw_code;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // leaves cfg_we high; the caller lowers it after the last write
    task automatic write_reg(input cfg_idx_t idx, input logic [MV_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        sb.configure(idx, value);
    endtask

    task automatic run_samples(input int count, input int hold_at);
        int unsigned top, aim, spread, code;
        top    = sb.max_code();
        aim    = $urandom_range(0, top);
        spread = top >> 5;
        for (int n = 0; n < count; n++) begin
            if (n == hold_at) hold_reqs <= hold_reqs + 1;
            if ($urandom_range(0, 24) == 0) aim = $urandom_range(0, top);
            if ($urandom_range(0, 7) == 0) begin
                code = $urandom;
            end else begin
                code = aim + $urandom_range(0, 2 * spread);
                code = (code < spread) ? 0 : code - spread;
                if (code > top) code = top;
            end
            send_sample(RAW_W'(code));
        end
    endtask

    initial begin
        logic [MV_W-1:0] fs, lo, hi, hy, bits_val, win_val;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // defaults, ring filling from empty, clamped codes
        foreach (WARMUP_CODES[i]) send_sample(WARMUP_CODES[i]);
        drain();
        // identity scaling, window of one: walk every threshold edge
        write_reg(CFG_FULL_SCALE, 16'hFFFF);
        write_reg(CFG_ADC_BITS, 16'd16);
        write_reg(CFG_WINDOW, 16'd1);
        cfg_we <= 1'b0;
        foreach (LEVEL_WALK_CODES[i]) send_sample(LEVEL_WALK_CODES[i]);
        drain();
        // zero window acts as one, level survives the clear
        write_reg(CFG_WINDOW, 16'd0);
        cfg_we <= 1'b0;
        send_sample(16'd4000);

        for (int p = 0; p < PHASES; p++) begin
            drain();
            idle_on <= (p != PHASES - 1) && (p % 5 != 2);
            fs = (p == 1) ? 16'd1 : (p == 2) ? 16'hFFFF : 16'($urandom_range(1000, 65535));
            lo = 16'($urandom_range(0, fs));
            hi = 16'($urandom_range(lo, fs));
            hy = (p == 2) ? 16'd0 : 16'($urandom_range(0, (hi - lo) / 2));
            if (p == 4) begin
                lo = 16'd0;
                hi = 16'hFFFF;
                hy = 16'hFFFF;
            end else if (p == 5) begin
                lo = 16'hFFFF;
                hi = 16'd0;
                hy = 16'($urandom);
            end
            case (p)
                1:       bits_val = 16'd8;
                2:       bits_val = 16'd16;
                3:       bits_val = 16'd0;
                5:       bits_val = 16'd31;
                6:       bits_val = 16'd7;
                8:       bits_val = 16'd17;
                default: bits_val = 16'($urandom_range(8, 16));
            endcase
            case (p)
                7:       win_val = 16'd1;
                8:       win_val = 16'd32;
                9:       win_val = 16'd0;
                10:      win_val = 16'd63;
                default: win_val = 16'($urandom_range(1, (p % 2 == 1) ? 32 : 8));
            endcase
            if (p % 2 == 1) begin
                bits_val = bits_val | (16'($urandom) & ~16'h001F);
                win_val  = win_val | (16'($urandom) & ~16'h003F);
            end
            write_reg(CFG_FULL_SCALE, fs);
            write_reg(CFG_ADC_BITS, bits_val);
            write_reg(CFG_LOW_TH, lo);
            write_reg(CFG_HIGH_TH, hi);
            write_reg(CFG_HYST, hy);
            if (p != 3) write_reg(CFG_WINDOW, win_val);
            cfg_we <= 1'b0;
            run_samples(PHASE_ITEMS, (p == 6) ? 20 : -1);
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
